/* rtl/core/ordered_list_engine_unit_macros.svh */
// Assertion macros for the list engine; clk and rst come from the using scope.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define OLE_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ole_pkg.sv */
`timescale 1ns / 1ps

package ole_pkg;

  localparam int TYPE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [TYPE_W-1:0] REQ_APPEND       = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PREPEND      = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_DROP_HEAD    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DROP_TAIL    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REMOVE_VALUE = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_REMOVE_INDEX = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0]         req_type;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

endpackage

/* rtl/core/ole_mem.sv */
`timescale 1ns / 1ps

module ole_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ole_ring.sv */
`timescale 1ns / 1ps

module ole_ring #(
  parameter int CAPACITY = 16,
  localparam int SW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic [SW-1:0] base,
  input  logic [CW-1:0] offset,
  output logic [SW-1:0] slot
);

  logic [SW:0] sum;

  always_comb begin
    sum = (SW + 1)'(base) + (SW + 1)'(offset);
    if (sum >= (SW + 1)'(CAPACITY)) begin
      slot = SW'(sum - (SW + 1)'(CAPACITY));
    end else begin
      slot = SW'(sum);
    end
  end

endmodule

/* rtl/core/ordered_list_engine_unit.sv */
// Channel   Handshake                    Payload
// request   start / busy (start & !busy) req    : ole_pkg::req_t
// result    done, one cycle strobe       result : ole_pkg::rsp_t
//
// Push, pop and unknown requests finish in the decode state; done is registered from it.
// Remove by value or index walks the ring, one stored entry per cycle through one
// read port and one ring adder.
// busy is high from acceptance until the result strobe; one request at a time.
// Synchronous reset empties the list; stored entries are not cleared.
// The receiver cannot stall: done lasts exactly one cycle.
`timescale 1ns / 1ps
`include "ordered_list_engine_unit_macros.svh"

module ordered_list_engine_unit #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ole_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output ole_pkg::rsp_t result
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > ole_pkg::INDEX_W) ? CW : ole_pkg::INDEX_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [1:0]                      state, state_next;
  logic [CW-1:0]                   item_count, count_next;
  logic [SW-1:0]                   front, front_next;
  logic                            wr_pend, wr_pend_next;
  logic                            cmp_valid, cmp_valid_next;
  logic [CW-1:0]                   rd_pos, rd_pos_next;
  logic [CW-1:0]                   cmp_pos, cmp_pos_next;
  logic [SW-1:0]                   rd_slot, rd_slot_next;
  logic [SW-1:0]                   wr_slot, wr_slot_next;
  logic [SW-1:0]                   dst_slot, dst_slot_next;
  logic [ole_pkg::TYPE_W-1:0]      cur_type;
  logic [VALUE_BITS-1:0]           cur_value;
  logic [ole_pkg::INDEX_W-1:0]     cur_index;
  logic                            fin;
  logic [ole_pkg::STATUS_W-1:0]    fin_status;

  logic [SW-1:0]         ring_base, ring_sum;
  logic [CW-1:0]         ring_offset;
  logic                  mem_we, mem_re;
  logic [SW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

  logic          full, empty, rd_more, hit, last_cmp, idx_out;
  logic [CW-1:0] idx_c;

  assign busy     = (state != S_IDLE);
  assign full     = (item_count == CW'(CAPACITY));
  assign empty    = (item_count == '0);
  assign rd_more  = (rd_pos < item_count);
  assign hit      = (mem_rdata == cur_value);
  assign last_cmp = ((cmp_pos + CW'(1)) == item_count);
  assign idx_out  = (XW'(cur_index) >= XW'(item_count));
  assign idx_c    = CW'(cur_index);

  ole_ring #(.CAPACITY(CAPACITY)) u_ring (
    .base   (ring_base),
    .offset (ring_offset),
    .slot   (ring_sum)
  );

  ole_mem #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_slot),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (state == S_DECODE) begin
      ring_base = front;
      case (cur_type)
        ole_pkg::REQ_APPEND:       ring_offset = item_count;
        ole_pkg::REQ_PREPEND:      ring_offset = CW'(CAPACITY - 1);
        ole_pkg::REQ_REMOVE_INDEX: ring_offset = (idx_c == '0) ? CW'(1) : idx_c;
        default:                   ring_offset = CW'(1);
      endcase
    end else begin
      ring_base   = rd_slot;
      ring_offset = CW'(1);
    end
  end

  always_comb begin
    mem_we    = (state == S_SHIFT) ? wr_pend :
                ((state == S_DECODE) && !full &&
                 (cur_type == ole_pkg::REQ_APPEND ||
                  cur_type == ole_pkg::REQ_PREPEND));
    mem_waddr = (state == S_SHIFT) ? wr_slot : ring_sum;
    mem_wdata = (state == S_SHIFT) ? mem_rdata : cur_value;
    mem_re    = rd_more && (state == S_SEARCH || state == S_SHIFT);
  end

  always_comb begin
    state_next     = state;
    count_next     = item_count;
    front_next     = front;
    wr_pend_next   = wr_pend;
    cmp_valid_next = cmp_valid;
    rd_pos_next    = rd_pos;
    cmp_pos_next   = cmp_pos;
    rd_slot_next   = rd_slot;
    wr_slot_next   = wr_slot;
    dst_slot_next  = dst_slot;
    fin            = 1'b0;
    fin_status     = ole_pkg::ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (cur_type)
          ole_pkg::REQ_APPEND: begin
            fin = 1'b1;
            if (full) fin_status = ole_pkg::ST_FULL;
            else count_next = item_count + CW'(1);
          end
          ole_pkg::REQ_PREPEND: begin
            fin = 1'b1;
            if (full) begin
              fin_status = ole_pkg::ST_FULL;
            end else begin
              front_next = ring_sum;
              count_next = item_count + CW'(1);
            end
          end
          ole_pkg::REQ_DROP_HEAD: begin
            fin = 1'b1;
            if (empty) begin
              fin_status = ole_pkg::ST_MISS;
            end else begin
              front_next = ring_sum;
              count_next = item_count - CW'(1);
            end
          end
          ole_pkg::REQ_DROP_TAIL: begin
            fin = 1'b1;
            if (empty) fin_status = ole_pkg::ST_MISS;
            else count_next = item_count - CW'(1);
          end
          ole_pkg::REQ_REMOVE_VALUE: begin
            if (empty) begin
              fin        = 1'b1;
              fin_status = ole_pkg::ST_MISS;
            end else begin
              rd_pos_next    = '0;
              rd_slot_next   = front;
              cmp_valid_next = 1'b0;
              state_next     = S_SEARCH;
            end
          end
          ole_pkg::REQ_REMOVE_INDEX: begin
            if (idx_out) begin
              fin        = 1'b1;
              fin_status = ole_pkg::ST_MISS;
            end else if (idx_c == '0) begin
              fin        = 1'b1;
              front_next = ring_sum;
              count_next = item_count - CW'(1);
            end else begin
              rd_pos_next   = idx_c;
              rd_slot_next  = ring_sum;
              dst_slot_next = ring_sum;
              wr_pend_next  = 1'b0;
              state_next    = S_SHIFT;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = ole_pkg::ST_MISS;
          end
        endcase
      end
      S_SEARCH: begin
        if (cmp_valid && hit) begin
          cmp_valid_next = 1'b0;
          if (cmp_pos == '0) begin
            fin        = 1'b1;
            front_next = rd_slot;
            count_next = item_count - CW'(1);
          end else begin
            wr_pend_next = 1'b0;
            state_next   = S_SHIFT;
          end
        end else if (cmp_valid && last_cmp) begin
          cmp_valid_next = 1'b0;
          fin            = 1'b1;
          fin_status     = ole_pkg::ST_MISS;
        end else if (rd_more) begin
          cmp_valid_next = 1'b1;
          cmp_pos_next   = rd_pos;
          rd_pos_next    = rd_pos + CW'(1);
          dst_slot_next  = rd_slot;
          rd_slot_next   = ring_sum;
        end else begin
          cmp_valid_next = 1'b0;
        end
      end
      S_SHIFT: begin
        if (rd_more) begin
          wr_pend_next  = 1'b1;
          wr_slot_next  = dst_slot;
          dst_slot_next = rd_slot;
          rd_pos_next   = rd_pos + CW'(1);
          rd_slot_next  = ring_sum;
        end else begin
          wr_pend_next = 1'b0;
          fin          = 1'b1;
          count_next   = item_count - CW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      item_count <= '0;
      front      <= '0;
      wr_pend    <= 1'b0;
      cmp_valid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      item_count <= count_next;
      front      <= front_next;
      wr_pend    <= wr_pend_next;
      cmp_valid  <= cmp_valid_next;
      done       <= fin;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos   <= rd_pos_next;
    cmp_pos  <= cmp_pos_next;
    rd_slot  <= rd_slot_next;
    wr_slot  <= wr_slot_next;
    dst_slot <= dst_slot_next;
    if (state == S_IDLE && start) begin
      cur_type  <= req.req_type;
      cur_value <= VALUE_BITS'($signed(req.value));
      cur_index <= req.index;
    end
    if (fin) begin
      result.status <= fin_status;
      result.count  <= ole_pkg::COUNT_W'(count_next);
    end
  end

  `OLE_ASSERT_HOLD(a_count_bound, 1'b1, item_count <= CW'(CAPACITY), "count above capacity")
  `OLE_ASSERT_HOLD(a_done_idle, done, state == S_IDLE, "result strobe while busy")
  `OLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request not taken")
  `OLE_ASSERT_HOLD(a_full_count, done && result.status == ole_pkg::ST_FULL, full, "refused push")
  `OLE_ASSERT_HOLD(a_wr_shift, wr_pend, state == S_SHIFT, "pending write outside shift")

endmodule
